// ===== rtl/core/i2c_register_master_macros.svh =====
// assertion macros for the i2c register master
// used by the top level only, compiled out when SYNTHESIS is set
`ifndef I2C_REGISTER_MASTER_MACROS_SVH
`define I2C_REGISTER_MASTER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define I2CRM_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed: lhs implies rhs");

// next-cycle implication
`define I2CRM_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed: lhs then rhs");

`else

`define I2CRM_ASSERT_IMP(label, clk, rst_n, lhs, rhs)
`define I2CRM_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)

`endif

`endif

// ===== rtl/core/i2crm_pkg.sv =====
// shared types and constants of the i2c register master
// no dependencies
package i2crm_pkg;

    localparam int BUF_DEPTH = 16;
    localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_LOAD   = 2'd1,
        OP_LAUNCH = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [13:0] {
        PH_IDLE      = 14'b00000000000001,
        PH_START1    = 14'b00000000000010,
        PH_ADDRW     = 14'b00000000000100,
        PH_ACK_ADDR  = 14'b00000000001000,
        PH_REG       = 14'b00000000010000,
        PH_ACK_REG   = 14'b00000000100000,
        PH_DATA      = 14'b00000001000000,
        PH_ACK_DATA  = 14'b00000010000000,
        PH_START2    = 14'b00000100000000,
        PH_ADDRR     = 14'b00001000000000,
        PH_ACK_ADDRR = 14'b00010000000000,
        PH_RDATA     = 14'b00100000000000,
        PH_RACK      = 14'b01000000000000,
        PH_STOP      = 14'b10000000000000
    } phase_t;

    typedef struct packed {
        op_t        operation;
        logic       sda_in;
        logic [6:0] slave_address;
        logic [7:0] register_address;
        logic       direction;
        logic [4:0] length;
        logic [7:0] data_byte;
        logic [3:0] byte_index;
    } item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic       status;
        logic       start_fault;
        logic       read_valid;
        logic [7:0] read_byte;
        logic [3:0] read_index;
    } result_t;

endpackage

// ===== rtl/core/i2crm_in_reg.sv =====
// input register of the i2c register master
// depends on i2crm_pkg
module i2crm_in_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  i2crm_pkg::item_t s_item,
    input  logic            take,
    output logic            item_valid,
    output i2crm_pkg::item_t item
);
    import i2crm_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== rtl/core/i2crm_engine.sv =====
// bus sequencer of the i2c register master: line state, counters, write buffer
// depends on i2crm_pkg
module i2crm_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  i2crm_pkg::item_t   item,
    output i2crm_pkg::result_t result
);
    import i2crm_pkg::*;

    logic             scl_reg, scl_next;
    logic             sda_reg, sda_next;
    phase_t           phase_reg, phase_next;
    logic [1:0]       sub_reg, sub_next;
    logic [3:0]       bit_reg, bit_next;
    logic [7:0]       shift_reg, shift_next;
    logic [CNT_W-1:0] bytes_done_reg, bytes_done_next;
    logic [CNT_W-1:0] byte_total_reg, byte_total_next;
    logic [6:0]       tgt_addr_reg, tgt_addr_next;
    logic [7:0]       tgt_regaddr_reg, tgt_regaddr_next;
    logic             read_mode_reg, read_mode_next;
    logic             fault_reg, fault_next;
    logic             status_reg, status_next;

    logic [7:0]       wbuf_reg [BUF_DEPTH];
    logic             buf_we;
    logic [BUF_AW-1:0] buf_waddr;

    logic [CNT_W-1:0] bd_inc;
    logic [CNT_W:0]   bd_wide;
    logic [7:0]       buf_first;
    logic [7:0]       buf_following;
    logic [7:0]       rd_shift;
    logic [3:0]       bit_inc;

    phase_t           pd_phase;
    logic [7:0]       pd_shift;
    logic [CNT_W-1:0] pd_bytes;

    logic             res_done;
    logic             res_valid;
    logic [7:0]       res_byte;
    logic [3:0]       res_index;

    assign bd_inc        = bytes_done_reg + CNT_W'(1);
    assign bd_wide       = {1'b0, bytes_done_reg} + (CNT_W + 1)'(1);
    assign buf_first     = wbuf_reg[0];
    assign buf_following = (int'(bd_inc) < BUF_DEPTH) ? wbuf_reg[BUF_AW'(bd_inc)] : 8'h00;
    assign rd_shift      = {shift_reg[6:0], item.sda_in};
    assign bit_inc       = bit_reg + 4'd1;
    assign buf_waddr     = BUF_AW'(item.byte_index);

    // where each phase goes once it has finished
    always_comb begin
        pd_phase = PH_IDLE;
        pd_shift = 8'h00;
        pd_bytes = bytes_done_reg;
        unique case (phase_reg)
            PH_START1:   begin
                pd_phase = PH_ADDRW;
                pd_shift = {tgt_addr_reg, 1'b0};
            end
            PH_ADDRW:    pd_phase = PH_ACK_ADDR;
            PH_ACK_ADDR: begin
                pd_phase = PH_REG;
                pd_shift = tgt_regaddr_reg;
            end
            PH_REG:      pd_phase = PH_ACK_REG;
            PH_ACK_REG:  begin
                pd_bytes = '0;
                if (read_mode_reg) begin
                    pd_phase = PH_START2;
                end else if (byte_total_reg != '0) begin
                    pd_phase = PH_DATA;
                    pd_shift = buf_first;
                end else begin
                    pd_phase = PH_STOP;
                end
            end
            PH_DATA:     pd_phase = PH_ACK_DATA;
            PH_ACK_DATA: begin
                pd_bytes = bd_inc;
                if (bd_inc < byte_total_reg) begin
                    pd_phase = PH_DATA;
                    pd_shift = buf_following;
                end else begin
                    pd_phase = PH_STOP;
                end
            end
            PH_START2:   begin
                pd_phase = PH_ADDRR;
                pd_shift = {tgt_addr_reg, 1'b1};
            end
            PH_ADDRR:    pd_phase = PH_ACK_ADDRR;
            PH_ACK_ADDRR: begin
                pd_bytes = '0;
                pd_phase = (byte_total_reg != '0) ? PH_RDATA : PH_STOP;
            end
            PH_RDATA:    begin
                pd_phase = PH_RACK;
                pd_shift = rd_shift;
            end
            PH_RACK:     begin
                pd_bytes = bd_inc;
                pd_phase = (bd_inc < byte_total_reg) ? PH_RDATA : PH_STOP;
            end
            default:     pd_phase = PH_IDLE;
        endcase
    end

    always_comb begin
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        phase_next       = phase_reg;
        sub_next         = sub_reg;
        bit_next         = bit_reg;
        shift_next       = shift_reg;
        bytes_done_next  = bytes_done_reg;
        byte_total_next  = byte_total_reg;
        tgt_addr_next    = tgt_addr_reg;
        tgt_regaddr_next = tgt_regaddr_reg;
        read_mode_next   = read_mode_reg;
        fault_next       = fault_reg;
        status_next      = status_reg;
        buf_we           = 1'b0;
        res_done         = 1'b0;
        res_valid        = 1'b0;
        res_byte         = 8'h00;
        res_index        = 4'h0;

        if (step) begin
            if (item.operation == OP_LOAD && phase_reg == PH_IDLE) begin
                buf_we = (int'(item.byte_index) < BUF_DEPTH);
            end else if (item.operation == OP_LAUNCH && phase_reg == PH_IDLE) begin
                tgt_addr_next    = item.slave_address;
                tgt_regaddr_next = item.register_address;
                read_mode_next   = item.direction;
                byte_total_next  = (int'(item.length) > BUF_DEPTH) ?
                                   CNT_W'(BUF_DEPTH) : CNT_W'(item.length);
                bytes_done_next  = '0;
                status_next      = 1'b0;
                phase_next       = PH_START1;
                sub_next         = 2'd0;
                bit_next         = 4'd0;
                shift_next       = 8'h00;
            end else if (item.operation == OP_TICK && phase_reg != PH_IDLE) begin
                unique case (phase_reg)
                    PH_START1, PH_START2: begin
                        if (sub_reg == 2'd0) begin
                            sda_next = 1'b1;
                            scl_next = 1'b1;
                            if (!item.sda_in) begin
                                fault_next = 1'b1;
                                phase_next = pd_phase;
                                sub_next   = 2'd0;
                                bit_next   = 4'd0;
                                shift_next = pd_shift;
                            end else begin
                                sub_next = 2'd1;
                            end
                        end else if (sub_reg == 2'd1) begin
                            sda_next = 1'b0;
                            if (item.sda_in) begin
                                fault_next = 1'b1;
                                phase_next = pd_phase;
                                sub_next   = 2'd0;
                                bit_next   = 4'd0;
                                shift_next = pd_shift;
                            end else begin
                                sub_next = 2'd2;
                            end
                        end else begin
                            sda_next   = 1'b0;
                            phase_next = pd_phase;
                            sub_next   = 2'd0;
                            bit_next   = 4'd0;
                            shift_next = pd_shift;
                        end
                    end
                    PH_ADDRW, PH_REG, PH_DATA, PH_ADDRR: begin
                        if (sub_reg == 2'd0) begin
                            scl_next = 1'b0;
                            sub_next = 2'd1;
                        end else if (sub_reg == 2'd1) begin
                            sda_next   = shift_reg[7];
                            shift_next = {shift_reg[6:0], 1'b0};
                            sub_next   = 2'd2;
                        end else begin
                            scl_next = 1'b1;
                            bit_next = bit_inc;
                            sub_next = 2'd0;
                            if (bit_inc >= 4'd8) begin
                                phase_next = pd_phase;
                                bit_next   = 4'd0;
                                shift_next = pd_shift;
                            end
                        end
                    end
                    PH_ACK_ADDR, PH_ACK_REG, PH_ACK_DATA, PH_ACK_ADDRR: begin
                        if (sub_reg == 2'd0) begin
                            scl_next = 1'b0;
                            sub_next = 2'd1;
                        end else if (sub_reg == 2'd1) begin
                            sda_next = 1'b1;
                            sub_next = 2'd2;
                        end else if (sub_reg == 2'd2) begin
                            scl_next = 1'b1;
                            if (phase_reg == PH_ACK_ADDR && item.sda_in) begin
                                status_next = 1'b1;
                                phase_next  = PH_STOP;
                                sub_next    = 2'd0;
                                bit_next    = 4'd0;
                                shift_next  = 8'h00;
                            end else begin
                                sub_next = 2'd3;
                            end
                        end else begin
                            scl_next        = 1'b0;
                            phase_next      = pd_phase;
                            sub_next        = 2'd0;
                            bit_next        = 4'd0;
                            shift_next      = pd_shift;
                            bytes_done_next = pd_bytes;
                        end
                    end
                    PH_RDATA: begin
                        if (sub_reg == 2'd0) begin
                            sda_next = 1'b1;
                            scl_next = 1'b0;
                            sub_next = 2'd1;
                        end else begin
                            scl_next   = 1'b1;
                            shift_next = rd_shift;
                            bit_next   = bit_inc;
                            sub_next   = 2'd0;
                            if (bit_inc >= 4'd8) begin
                                res_valid  = 1'b1;
                                res_byte   = rd_shift;
                                res_index  = 4'(bytes_done_reg);
                                phase_next = pd_phase;
                                bit_next   = 4'd0;
                                shift_next = pd_shift;
                            end
                        end
                    end
                    PH_RACK: begin
                        if (sub_reg == 2'd0) begin
                            scl_next = 1'b0;
                            sub_next = 2'd1;
                        end else if (sub_reg == 2'd1) begin
                            // nack after the last byte
                            sda_next = (bd_wide >= {1'b0, byte_total_reg});
                            sub_next = 2'd2;
                        end else if (sub_reg == 2'd2) begin
                            scl_next = 1'b1;
                            sub_next = 2'd3;
                        end else begin
                            scl_next        = 1'b0;
                            phase_next      = pd_phase;
                            sub_next        = 2'd0;
                            bit_next        = 4'd0;
                            shift_next      = pd_shift;
                            bytes_done_next = pd_bytes;
                        end
                    end
                    PH_STOP: begin
                        if (sub_reg == 2'd0) begin
                            scl_next = 1'b0;
                            sub_next = 2'd1;
                        end else if (sub_reg == 2'd1) begin
                            sda_next = 1'b0;
                            sub_next = 2'd2;
                        end else if (sub_reg == 2'd2) begin
                            scl_next = 1'b1;
                            sub_next = 2'd3;
                        end else begin
                            sda_next   = 1'b1;
                            res_done   = 1'b1;
                            phase_next = PH_IDLE;
                            sub_next   = 2'd0;
                            bit_next   = 4'd0;
                            shift_next = 8'h00;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                        sub_next   = 2'd0;
                        bit_next   = 4'd0;
                        shift_next = 8'h00;
                    end
                endcase
            end
        end
    end

    always_comb begin
        result.scl_out     = scl_next;
        result.sda_out     = sda_next;
        result.busy_res    = (phase_next != PH_IDLE);
        result.done_res    = res_done;
        result.status      = status_next;
        result.start_fault = fault_next;
        result.read_valid  = res_valid;
        result.read_byte   = res_byte;
        result.read_index  = res_index;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            phase_reg       <= PH_IDLE;
            sub_reg         <= 2'd0;
            bit_reg         <= 4'd0;
            shift_reg       <= 8'h00;
            bytes_done_reg  <= '0;
            byte_total_reg  <= '0;
            tgt_addr_reg    <= 7'h00;
            tgt_regaddr_reg <= 8'h00;
            read_mode_reg   <= 1'b0;
            fault_reg       <= 1'b0;
            status_reg      <= 1'b0;
        end else begin
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
            phase_reg       <= phase_next;
            sub_reg         <= sub_next;
            bit_reg         <= bit_next;
            shift_reg       <= shift_next;
            bytes_done_reg  <= bytes_done_next;
            byte_total_reg  <= byte_total_next;
            tgt_addr_reg    <= tgt_addr_next;
            tgt_regaddr_reg <= tgt_regaddr_next;
            read_mode_reg   <= read_mode_next;
            fault_reg       <= fault_next;
            status_reg      <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (buf_we) begin
            wbuf_reg[buf_waddr] <= item.data_byte;
        end
    end

endmodule

// ===== rtl/core/i2crm_out_reg.sv =====
// result register of the i2c register master
// depends on i2crm_pkg
module i2crm_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  i2crm_pkg::result_t d_result,
    output logic               free,
    output logic               m_valid,
    input  logic               m_ready,
    output i2crm_pkg::result_t m_result
);
    import i2crm_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign free     = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= d_result;
        end
    end

endmodule

// ===== rtl/core/i2c_register_master.sv =====
// top level of the i2c register master: request stream in, line/status stream out
// depends on i2crm_pkg, i2crm_in_reg, i2crm_engine, i2crm_out_reg and the macro header
//
// Every request yields exactly one result. A request is taken every clock while the
// result side keeps up. Its result is presented once the request has sat in the input
// register while the step logic works out the result and the result register has
// captured it. A stalled result holds the step logic, and once the input register is
// full the request side stalls too. Each tick request moves the bus by one line step,
// so the bus rate is set by the tick rate. Write buffer slots are undefined until
// loaded and there is no clearing pass after reset. Loads and launches while busy are
// ignored.
`include "i2c_register_master_macros.svh"
module i2c_register_master (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sda_in, slave_address, register_address, direction, length, data_byte,
    // byte_index, zero fill
    input  logic [i2crm_pkg::IN_DATA_W-1:0]     s_tdata,
    // operation
    input  logic [i2crm_pkg::IN_USER_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // scl_out, sda_out, busy_res, done_res, status, start_fault, read_valid,
    // read_byte, read_index, zero fill
    output logic [i2crm_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import i2crm_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    out_free;
    logic    fire;
    result_t eng_result;
    result_t out_result;
    logic    launch_seen;
    logic    done_seen;

    always_comb begin
        s_item.operation        = op_t'(s_tuser[1:0]);
        s_item.sda_in           = s_tdata[0];
        s_item.slave_address    = s_tdata[7:1];
        s_item.register_address = s_tdata[15:8];
        s_item.direction        = s_tdata[16];
        s_item.length           = s_tdata[21:17];
        s_item.data_byte        = s_tdata[29:22];
        s_item.byte_index       = s_tdata[33:30];
    end

    assign fire = item_valid && out_free;

    i2crm_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    i2crm_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (fire),
        .item    (item),
        .result  (eng_result)
    );

    i2crm_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .d_result (eng_result),
        .free     (out_free),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (out_result)
    );

    assign m_tdata = {5'd0,
                      out_result.read_index,
                      out_result.read_byte,
                      out_result.read_valid,
                      out_result.start_fault,
                      out_result.status,
                      out_result.done_res,
                      out_result.busy_res,
                      out_result.sda_out,
                      out_result.scl_out};

    assign launch_seen = fire && (item.operation == OP_LAUNCH) &&
                         m_tvalid && !out_result.busy_res;
    assign done_seen   = fire && eng_result.done_res;

    // a stalled result blocks the step logic
    `I2CRM_ASSERT_IMP(a_no_step_on_stall, aclk, aresetn, m_tvalid && !m_tready, !fire)
    // a launch while idle shows busy in its result
    `I2CRM_ASSERT_NEXT(a_launch_busy, aclk, aresetn, launch_seen, m_tvalid && m_tdata[2])
    // the final stop step leaves the block idle
    `I2CRM_ASSERT_NEXT(a_done_idle, aclk, aresetn, done_seen, m_tvalid && m_tdata[3] && !m_tdata[2])

endmodule
